// File: sv/exg_pkg.sv
package exg_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LEAVE_THRESHOLD  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DWELL_LIMIT      = 2'd2;

  localparam int QUEUE_DEPTH = 2;

  localparam logic signed [31:0] TRIP_BOUND = 32'sd64000;
  localparam logic [31:0]        MOST_NEG   = 32'h8000_0000;

  typedef struct packed {
    logic signed [31:0] error_value;
    logic               ge_settle;
    logic               ge_leave;
    logic               sign_flip;
  } exg_item_t;

endpackage

// File: sv/exg_in_if.sv
interface exg_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] error_value;
  logic signed [31:0] newest_sample;
  logic signed [31:0] previous_sample;

  modport source(output valid, output error_value, output newest_sample,
                 output previous_sample, input ready);
  modport sink(input valid, input error_value, input newest_sample,
               input previous_sample, output ready);
endinterface

// File: sv/exg_out_if.sv
interface exg_out_if;
  logic       valid;
  logic       ready;
  logic       gate_adjusting;
  logic [1:0] gate_mode;
  logic       accum_tripped;

  modport source(output valid, output gate_adjusting, output gate_mode,
                 output accum_tripped, input ready);
  modport sink(input valid, input gate_adjusting, input gate_mode,
               input accum_tripped, output ready);
endinterface

// File: sv/exposure_convergence_gate.sv
// A transaction accepted at the input is written into the queue, then taken into the
// output register, where its result waits until it is accepted.
// Throughput: one transaction per cycle while the output register is free or being accepted,
// mode and accumulator updated as each is taken; a two-entry queue separates front and back.
// Reset: synchronous, active high; clears the queue, the output valid flag, the
// accumulator, the dwell counter and the configuration registers, and enters idle mode.
module exposure_convergence_gate
  import exg_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  exg_in_if.sink                 frame_in,
  exg_out_if.source              gate_out,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [7:0] settle_threshold;
  logic [7:0] leave_threshold;
  logic [7:0] dwell_limit;
  logic       push_valid;
  logic       push_ready;
  exg_item_t  push_item;
  logic       pop_valid;
  logic       pop_ready;
  exg_item_t  pop_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_threshold <= '0;
      leave_threshold  <= '0;
      dwell_limit      <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SETTLE_THRESHOLD: settle_threshold <= cfg_data;
        CFG_LEAVE_THRESHOLD:  leave_threshold  <= cfg_data;
        CFG_DWELL_LIMIT:      dwell_limit      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  exg_front u_front (
    .frame_in         (frame_in),
    .settle_threshold (settle_threshold),
    .leave_threshold  (leave_threshold),
    .push_valid       (push_valid),
    .push_ready       (push_ready),
    .push_item        (push_item)
  );

  exg_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  exg_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_item    (pop_item),
    .dwell_limit (dwell_limit),
    .gate_out    (gate_out)
  );

endmodule

// File: sv/exg_fifo.sv
module exg_fifo
  import exg_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_ready,
  input  exg_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output exg_item_t pop_item
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  exg_item_t       entries [Depth];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            push;
  logic            pop;

  assign push_ready = (count != CW'(Depth));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: sv/exg_front.sv
module exg_front
  import exg_pkg::*;
(
  exg_in_if.sink           frame_in,
  input  logic [7:0]       settle_threshold,
  input  logic [7:0]       leave_threshold,
  output logic             push_valid,
  input  logic             push_ready,
  output exg_item_t        push_item
);

  logic [31:0] err_mag;
  logic        err_is_min;
  logic [31:0] settle_bound;
  logic [31:0] leave_bound;
  logic [31:0] prod_lo;

  // The most negative error has no positive 32-bit magnitude, so err_is_min masks it
  // and it never counts as reaching either bound.
  assign err_mag      = frame_in.error_value[31] ? (~frame_in.error_value + 32'd1)
                                                 : frame_in.error_value;
  assign err_is_min   = (frame_in.error_value == MOST_NEG);
  assign settle_bound = {20'd0, settle_threshold, 4'd0};
  assign leave_bound  = {20'd0, leave_threshold, 4'd0};
  assign prod_lo      = frame_in.newest_sample * frame_in.previous_sample;

  assign frame_in.ready = push_ready;
  assign push_valid     = frame_in.valid;

  always_comb begin
    push_item.error_value = frame_in.error_value;
    push_item.ge_settle   = !err_is_min && (err_mag >= settle_bound);
    push_item.ge_leave    = !err_is_min && (err_mag >= leave_bound);
    push_item.sign_flip   = prod_lo[31];
  end

endmodule

// File: sv/exg_back.sv
module exg_back
  import exg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  exg_item_t   pop_item,
  input  logic [7:0]  dwell_limit,
  exg_out_if.source   gate_out
);

  typedef enum logic [1:0] {
    IDLE      = 2'd0,
    ADJUSTING = 2'd1,
    SETTLED   = 2'd2
  } mode_t;

  mode_t              state;
  mode_t              state_next;
  logic [8:0]         dwell;
  logic [8:0]         dwell_next;
  logic [8:0]         dwell_inc;
  logic signed [31:0] accum;
  logic signed [31:0] accum_sum;
  logic               trip;
  logic               take;
  logic               out_valid;
  logic               out_adjusting;
  logic [1:0]         out_mode;
  logic               out_tripped;

  assign pop_ready = !out_valid || gate_out.ready;
  assign take      = pop_valid && pop_ready;
  assign accum_sum = accum + pop_item.error_value;
  assign dwell_inc = dwell + 9'd1;
  assign trip      = (accum_sum > TRIP_BOUND) ||
                     ((accum_sum < -TRIP_BOUND) && (accum_sum != MOST_NEG));

  always_comb begin
    state_next = (state == IDLE) ? ADJUSTING : state;
    dwell_next = dwell;
    unique case (state_next)
      ADJUSTING: begin
        if (pop_item.ge_settle) begin
          dwell_next = '0;
        end else begin
          dwell_next = dwell_inc;
          if (dwell_inc > {1'b0, dwell_limit}) begin
            state_next = SETTLED;
            dwell_next = '0;
          end
        end
      end
      SETTLED: begin
        if (pop_item.ge_leave) begin
          dwell_next = dwell_inc;
          if (dwell_inc >= {1'b0, dwell_limit}) begin
            state_next = ADJUSTING;
            dwell_next = '0;
          end
        end else begin
          dwell_next = '0;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
    if (pop_item.sign_flip) begin
      state_next = SETTLED;
      dwell_next = '0;
    end
    if (trip) begin
      state_next = ADJUSTING;
      dwell_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      dwell     <= '0;
      accum     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        state     <= state_next;
        dwell     <= dwell_next;
        accum     <= trip ? 32'sd0 : accum_sum;
        out_valid <= 1'b1;
      end else if (gate_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_adjusting <= trip || (state_next == ADJUSTING);
      out_mode      <= state_next;
      out_tripped   <= trip;
    end
  end

  assign gate_out.valid          = out_valid;
  assign gate_out.gate_adjusting = out_adjusting;
  assign gate_out.gate_mode      = out_mode;
  assign gate_out.accum_tripped  = out_tripped;

`ifndef SYNTH
  a_trip_forces_adjusting: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_tripped |-> out_adjusting && (out_mode == ADJUSTING))
    else $error("Tripped result does not report adjusting mode.");

  a_trip_clears_accum: assert property (@(posedge clk) disable iff (rst)
    take && trip |=> (accum == 32'sd0) && (dwell == 9'd0))
    else $error("Accumulator or dwell not cleared after a trip.");

  a_dwell_bound: assert property (@(posedge clk) disable iff (rst)
    dwell <= 9'd256)
    else $error("Dwell counter exceeded its bound.");

  a_take_fills_output: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid && (out_mode == state))
    else $error("Accepted transaction did not produce a matching result.");
`endif

endmodule

// File: bench/tb_exposure_convergence_gate.sv
`timescale 1ns / 1ps

module tb_exposure_convergence_gate;
  import exg_pkg::*;

  localparam logic [1:0] MODE_IDLE      = 2'd0;
  localparam logic [1:0] MODE_ADJUSTING = 2'd1;
  localparam logic [1:0] MODE_SETTLED   = 2'd2;

  localparam int LONG_STALL_AT     = 900;
  localparam int LONG_STALL_CYCLES = 100;

  typedef struct packed {
    logic [31:0] err;
    logic [31:0] newest;
    logic [31:0] previous;
  } frame_t;

  typedef struct packed {
    logic       adjusting;
    logic [1:0] mode;
    logic       tripped;
  } gate_result_t;

  typedef enum int {QUIET_RUN, LOUD_RUN, MIXED_RUN} error_regime_e;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  exg_in_if  frame_if();
  exg_out_if gate_if();

  exposure_convergence_gate DUT (
    .clk       (clk),
    .rst       (rst),
    .frame_in  (frame_if),
    .gate_out  (gate_if),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  logic [7:0]  settle_thr;
  logic [7:0]  leave_thr;
  logic [7:0]  dwell_lim;
  logic [31:0] accum_m;
  logic [1:0]  mode_m;
  logic [8:0]  dwell_m;

  frame_t       frame_q[$];
  gate_result_t expected_gate_q[$];
  frame_t       cur_frame;
  gate_result_t want;
  bit           offering;
  bit           steady_in;
  bit           steady_out;
  int           send_wait;
  int           recv_wait;
  int           frames_sent;
  int           results_seen;
  int           trips_seen;
  int           settled_seen;
  int           settings_used;
  int           errors;

  always #5 clk = ~clk;

  function automatic longint wrapped_magnitude(input logic [31:0] v);
    longint s;
    s = longint'($signed(v));
    if (s < 0 && v != MOST_NEG) begin
      s = -s;
    end
    return s;
  endfunction

  function automatic gate_result_t predict_gate_step(input frame_t f);
    longint       mag;
    logic [31:0]  prod;
    gate_result_t r;
    mag = wrapped_magnitude(f.err);
    r.tripped = 1'b0;
    accum_m = accum_m + f.err;
    if (mode_m == MODE_IDLE) begin
      mode_m = MODE_ADJUSTING;
    end
    case (mode_m)
      MODE_ADJUSTING: begin
        if (mag >= longint'(settle_thr) * 16) begin
          dwell_m = '0;
        end else begin
          dwell_m = dwell_m + 9'd1;
          if (dwell_m > {1'b0, dwell_lim}) begin
            mode_m = MODE_SETTLED;
            dwell_m = '0;
          end
        end
      end
      MODE_SETTLED: begin
        if (mag >= longint'(leave_thr) * 16) begin
          dwell_m = dwell_m + 9'd1;
          if (dwell_m >= {1'b0, dwell_lim}) begin
            mode_m = MODE_ADJUSTING;
            dwell_m = '0;
          end
        end else begin
          dwell_m = '0;
        end
      end
      default: begin
        mode_m = MODE_IDLE;
      end
    endcase
    prod = f.newest * f.previous;
    if (prod[31]) begin
      mode_m = MODE_SETTLED;
      dwell_m = '0;
    end
    if (wrapped_magnitude(accum_m) > longint'(TRIP_BOUND)) begin
      mode_m = MODE_ADJUSTING;
      accum_m = '0;
      dwell_m = '0;
      r.tripped = 1'b1;
    end
    r.mode = mode_m;
    r.adjusting = r.tripped || (mode_m == MODE_ADJUSTING);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      frame_if.valid <= 1'b0;
      offering = 1'b0;
      send_wait = 0;
    end else begin
      if (frame_if.valid && frame_if.ready) begin
        expected_gate_q.push_back(predict_gate_step(cur_frame));
        frames_sent++;
        offering = 1'b0;
      end
      if (!offering) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (frame_q.size() > 0) begin
          cur_frame = frame_q.pop_front();
          offering = 1'b1;
          frame_if.error_value     <= cur_frame.err;
          frame_if.newest_sample   <= cur_frame.newest;
          frame_if.previous_sample <= cur_frame.previous;
          send_wait = steady_in ? 0 : $urandom_range(0, 11);
        end
      end
      frame_if.valid <= offering;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      gate_if.ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (gate_if.valid && gate_if.ready) begin
        if (expected_gate_q.size() == 0) begin
          $display("%0t: result with nothing expected: adjusting %0d mode %0d tripped %0d",
                   $time, gate_if.gate_adjusting, gate_if.gate_mode, gate_if.accum_tripped);
          errors++;
        end else begin
          want = expected_gate_q.pop_front();
          if (gate_if.gate_adjusting !== want.adjusting) begin
            $display("%0t: gate_adjusting expected %0d actual %0d",
                     $time, want.adjusting, gate_if.gate_adjusting);
            errors++;
          end
          if (gate_if.gate_mode !== want.mode) begin
            $display("%0t: gate_mode expected %0d actual %0d",
                     $time, want.mode, gate_if.gate_mode);
            errors++;
          end
          if (gate_if.accum_tripped !== want.tripped) begin
            $display("%0t: accum_tripped expected %0d actual %0d",
                     $time, want.tripped, gate_if.accum_tripped);
            errors++;
          end
        end
        results_seen++;
        if (gate_if.accum_tripped) begin
          trips_seen++;
        end
        if (gate_if.gate_mode == MODE_SETTLED) begin
          settled_seen++;
        end
        recv_wait = steady_out ? 0 : $urandom_range(0, 11);
        if (results_seen == LONG_STALL_AT) begin
          recv_wait = LONG_STALL_CYCLES;
        end
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      gate_if.ready <= (recv_wait == 0);
    end
  end

  task automatic add_frame(input logic [31:0] err, input logic [31:0] newest,
                           input logic [31:0] previous);
    frame_t f;
    f.err = err;
    f.newest = newest;
    f.previous = previous;
    frame_q.push_back(f);
  endtask

  task automatic wait_until_drained();
    do begin
      @(negedge clk);
    end while (frame_q.size() != 0 || frame_if.valid || expected_gate_q.size() != 0);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_SETTLE_THRESHOLD: settle_thr = val;
      CFG_LEAVE_THRESHOLD:  leave_thr = val;
      CFG_DWELL_LIMIT:      dwell_lim = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_gate_config(input logic [7:0] settle, input logic [7:0] leave,
                                 input logic [7:0] dwell);
    wait_until_drained();
    write_register(CFG_SETTLE_THRESHOLD, settle);
    write_register(CFG_LEAVE_THRESHOLD, leave);
    write_register(CFG_DWELL_LIMIT, dwell);
    settings_used++;
    @(negedge clk);
  endtask

  task automatic queue_random_frames(input int count, input int noise_pct);
    frame_t        f;
    error_regime_e regime;
    int            regime_left;
    int            roll;
    int            mag;
    int            quiet_top;
    bit            neg_turn;
    regime = MIXED_RUN;
    regime_left = 0;
    neg_turn = 1'b0;
    quiet_top = (settle_thr * 16 - 1 > 1000) ? 1000 : settle_thr * 16 - 1;
    for (int i = 0; i < count; i++) begin
      if (regime_left == 0) begin
        roll = $urandom_range(0, 99);
        regime = (roll < 40) ? QUIET_RUN : (roll < 75) ? LOUD_RUN : MIXED_RUN;
        regime_left = $urandom_range(1, dwell_lim + dwell_lim / 4 + 8);
      end
      regime_left--;
      roll = $urandom_range(0, 99);
      if (roll < noise_pct / 2) begin
        f.err = $urandom;
        f.newest = $urandom;
        f.previous = $urandom;
      end else begin
        case (regime)
          QUIET_RUN: mag = (settle_thr == 0) ? 0 : $urandom_range(0, quiet_top);
          LOUD_RUN:  mag = leave_thr * 16 + $urandom_range(0, 200);
          default:   mag = $urandom_range(0, 4200);
        endcase
        if (regime == MIXED_RUN) begin
          neg_turn = 1'($urandom_range(0, 1));
        end
        f.err = neg_turn ? -mag : mag;
        neg_turn = ~neg_turn;
        f.newest = $urandom_range(0, 40000);
        f.previous = $urandom_range(0, 40000);
        if ($urandom_range(0, 1)) begin
          f.newest = -f.newest;
          f.previous = -f.previous;
        end
        if (roll < noise_pct) begin
          f.newest = -f.newest;
        end
      end
      frame_q.push_back(f);
    end
  endtask

  task automatic run_phase(input logic [7:0] settle, input logic [7:0] leave,
                           input logic [7:0] dwell, input int count, input int noise_pct,
                           input bit fast_in, input bit fast_out);
    set_gate_config(settle, leave, dwell);
    steady_in = fast_in;
    steady_out = fast_out;
    queue_random_frames(count, noise_pct);
    wait_until_drained();
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    frame_if.valid = 1'b0;
    frame_if.error_value = '0;
    frame_if.newest_sample = '0;
    frame_if.previous_sample = '0;
    gate_if.ready = 1'b0;
    settle_thr = '0;
    leave_thr = '0;
    dwell_lim = '0;
    accum_m = '0;
    mode_m = MODE_IDLE;
    dwell_m = '0;
    steady_in = 1'b0;
    steady_out = 1'b0;
    frames_sent = 0;
    results_seen = 0;
    trips_seen = 0;
    settled_seen = 0;
    settings_used = 1;
    errors = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    add_frame(32'd0, 32'd0, 32'd0);
    add_frame(MOST_NEG, 32'd0, 32'd0);
    add_frame(MOST_NEG, 32'd0, 32'd0);
    add_frame(32'd1, 32'hFFFF_FFFF, 32'd1);
    add_frame(32'h7FFF_FFFF, 32'd0, 32'd0);
    add_frame(32'hFFFF_FFFF, MOST_NEG, MOST_NEG);
    wait_until_drained();

    set_gate_config(8'd4, 8'd4, 8'd2);
    add_frame(32'd63, 32'd100, 32'd200);
    add_frame(-32'sd63, 32'd100, 32'd200);
    add_frame(32'd0, 32'd100, 32'd200);
    add_frame(32'd64, 32'd100, 32'd200);
    add_frame(-32'sd64, 32'd100, 32'd200);
    add_frame(32'd10, 32'd100, 32'd200);
    add_frame(32'd100, 32'd100, 32'd200);
    add_frame(32'd63891, 32'd0, 32'd0);
    add_frame(32'd1, 32'd0, 32'd0);
    add_frame(32'd1, 32'd0, 32'd0);
    add_frame(-32'sd64000, 32'd0, 32'd0);
    add_frame(-32'sd1, 32'd0, 32'd0);
    add_frame(32'd0, 32'h0001_0000, 32'h0000_8000);
    add_frame(32'd0, -32'sd5, -32'sd7);
    add_frame(32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_frame(32'd0, MOST_NEG, 32'd1);
    add_frame(32'h7FFF_FFFF, 32'h7FFF_FFFF, MOST_NEG);
    add_frame(MOST_NEG, MOST_NEG, 32'h7FFF_FFFF);
    add_frame(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    wait_until_drained();

    run_phase(8'd0, 8'd0, 8'd0, 150, 20, 1'b0, 1'b0);
    run_phase(8'd255, 8'd255, 8'd255, 600, 0, 1'b1, 1'b1);
    run_phase(8'd255, 8'd0, 8'd3, 200, 15, 1'b0, 1'b1);
    run_phase(8'd8, 8'd200, 8'd5, 300, 10, 1'b1, 1'b0);
    run_phase(8'd0, 8'd255, 8'd0, 150, 10, 1'b0, 1'b0);
    repeat (3) begin
      run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 40)), 100, 15, 1'b0, 1'b0);
    end

    wait_until_drained();
    repeat (10) @(posedge clk);
    $display("Ran %0d frames over %0d configuration settings.", frames_sent, settings_used);
    $display("Saw %0d accumulator trips and %0d settled results.", trips_seen, settled_seen);
    if (errors == 0 && expected_gate_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// File: files.f
sv/exg_pkg.sv
sv/exg_in_if.sv
sv/exg_out_if.sv
sv/exg_fifo.sv
sv/exg_front.sv
sv/exg_back.sv
sv/exposure_convergence_gate.sv
bench/tb_exposure_convergence_gate.sv
